/* src/rre_pkg.sv */
// Shared types, codes and constants of the rectangle raster engine.
package rre_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS  = 8;

  localparam int OP_W     = 2;
  localparam int COORD_W  = 18;
  localparam int SIZE_W   = 17;
  localparam int CHAR_W   = 8;
  localparam int PIX_W    = 8;
  localparam int SCAN_W   = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [SCAN_W-1:0] RST_CANVAS_WIDTH  = SCAN_W'(256);
  localparam logic [SCAN_W-1:0] RST_CANVAS_HEIGHT = SCAN_W'(256);
  localparam logic [CHAR_W-1:0] RST_BACKGROUND    = CHAR_W'(32);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CANVAS_WIDTH  = 2'd0,
    CFG_CANVAS_HEIGHT = 2'd1,
    CFG_BACKGROUND    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } state_e;

  typedef struct packed {
    logic load;      // latch a clear or draw transaction, start the scan
    logic step;      // handle one pixel of the scan
    logic rd_issue;  // read one canvas entry for a read transaction
    logic out_load;  // move the read data into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;     // active area has no pixel
    logic last;      // scan stands on the last active pixel
  } ctrl_sts_t;

endpackage

/* src/rre_in_if.sv */
// Input channel of the rectangle raster engine: valid, ready and item payload.
interface rre_in_if import rre_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic                 filled;
  logic [COORD_W-1:0]   rect_x;
  logic [COORD_W-1:0]   rect_y;
  logic [SIZE_W-1:0]    rect_width;
  logic [SIZE_W-1:0]    rect_height;
  logic [CHAR_W-1:0]    fill_char;
  logic [PIX_W-1:0]     pixel_col;
  logic [PIX_W-1:0]     pixel_row;

  modport source (
    output valid, operation, filled, rect_x, rect_y, rect_width, rect_height,
           fill_char, pixel_col, pixel_row,
    input  ready
  );

  modport sink (
    input  valid, operation, filled, rect_x, rect_y, rect_width, rect_height,
           fill_char, pixel_col, pixel_row,
    output ready
  );
endinterface

/* src/rre_out_if.sv */
// Output channel of the rectangle raster engine: valid, ready and read result.
interface rre_out_if import rre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] pixel_char;

  modport source (
    output valid, pixel_char,
    input  ready
  );

  modport sink (
    input  valid, pixel_char,
    output ready
  );
endinterface

/* src/rre_ctrl.sv */
// Controller of the rectangle raster engine: sequencing of scans and reads.
module rre_ctrl import rre_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] in_op_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ctrl_cmd_t       cmd_o,
  input  ctrl_sts_t       sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_op_i)
            OP_CLEAR, OP_DRAW: begin
              if (!sts_i.empty) state_d = ST_SCAN;
            end
            OP_READ: state_d = ST_READ;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts_i.last) state_d = ST_IDLE;
      end
      ST_READ: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_op_i)
            OP_CLEAR, OP_DRAW: cmd_o.load = !sts_i.empty;
            OP_READ:           cmd_o.rd_issue = 1'b1;
            default:           cmd_o = '0;
          endcase
        end
      end
      ST_SCAN: cmd_o.step     = 1'b1;
      ST_READ: cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  // A fresh load wins over the drain of the previous result.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/rre_datapath.sv */
// Datapath of the rectangle raster engine: config, scan counters, canvas store.
module rre_datapath import rre_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  ctrl_cmd_t             cmd_i,
  output ctrl_sts_t             sts_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic                  filled_i,
  input  logic [COORD_W-1:0]    rect_x_i,
  input  logic [COORD_W-1:0]    rect_y_i,
  input  logic [SIZE_W-1:0]     rect_width_i,
  input  logic [SIZE_W-1:0]     rect_height_i,
  input  logic [CHAR_W-1:0]     fill_char_i,
  input  logic [PIX_W-1:0]      pixel_col_i,
  input  logic [PIX_W-1:0]      pixel_row_i,
  output logic [CHAR_W-1:0]     pixel_char_o
);

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SCAN_MAX = (1 << SCAN_W) - 1;
  localparam int POS_W   = SCAN_W + FRAC_BITS;
  localparam int CALC_W  = ((POS_W > COORD_W) ? POS_W : COORD_W) + 2;
  localparam logic [SCAN_W-1:0] W_CAP =
    SCAN_W'((MAX_WIDTH > SCAN_MAX) ? SCAN_MAX : MAX_WIDTH);
  localparam logic [SCAN_W-1:0] H_CAP =
    SCAN_W'((MAX_HEIGHT > SCAN_MAX) ? SCAN_MAX : MAX_HEIGHT);
  localparam logic signed [CALC_W-1:0] ONE = CALC_W'(1) <<< FRAC_BITS;

  // Configuration registers.
  logic [SCAN_W-1:0] cw_q, ch_q;
  logic [CHAR_W-1:0] bg_q;
  logic [SCAN_W-1:0] aw, ah;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q <= RST_CANVAS_WIDTH;
      ch_q <= RST_CANVAS_HEIGHT;
      bg_q <= RST_BACKGROUND;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CANVAS_WIDTH:  cw_q <= cfg_data_i[SCAN_W-1:0];
        CFG_CANVAS_HEIGHT: ch_q <= cfg_data_i[SCAN_W-1:0];
        CFG_BACKGROUND:    bg_q <= cfg_data_i[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  assign aw = (cw_q > W_CAP) ? W_CAP : cw_q;
  assign ah = (ch_q > H_CAP) ? H_CAP : ch_q;

  // Latched scan item.
  logic                      draw_q, filled_q;
  logic [CHAR_W-1:0]         fill_q;
  logic signed [COORD_W-1:0] x_q, y_q;
  logic [SIZE_W-1:0]         w_q, h_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      draw_q   <= (operation_i == OP_DRAW);
      filled_q <= filled_i;
      fill_q   <= fill_char_i;
      x_q      <= rect_x_i;
      y_q      <= rect_y_i;
      w_q      <= rect_width_i;
      h_q      <= rect_height_i;
    end
  end

  // Scan counters.
  logic [SCAN_W-1:0] col_q, row_q;
  logic [ADDR_W-1:0] base_q;
  logic              row_end;

  assign row_end   = (col_q == aw - SCAN_W'(1));
  assign sts_o.last = row_end && (row_q == ah - SCAN_W'(1));
  assign sts_o.empty = (aw == '0) || (ah == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      base_q <= '0;
    end else if (cmd_i.step) begin
      if (sts_o.last) begin
        col_q  <= '0;
        row_q  <= '0;
        base_q <= '0;
      end else if (row_end) begin
        col_q  <= '0;
        row_q  <= row_q + SCAN_W'(1);
        base_q <= base_q + ADDR_W'(MAX_WIDTH);
      end else begin
        col_q <= col_q + SCAN_W'(1);
      end
    end
  end

  // Pixel classification against the rectangle.
  logic signed [CALC_W-1:0] p, q, x, y, w, h, dxl, dxr, dyt, dyb;
  logic outside, border, wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CHAR_W-1:0] wr_data;

  always_comb begin
    p   = CALC_W'(col_q) <<< FRAC_BITS;
    q   = CALC_W'(row_q) <<< FRAC_BITS;
    x   = CALC_W'(x_q);
    y   = CALC_W'(y_q);
    w   = CALC_W'(w_q);
    h   = CALC_W'(h_q);
    dxl = p - x;
    dyt = q - y;
    dxr = x + w - p;
    dyb = y + h - q;
    outside = dxl[CALC_W-1] || dyt[CALC_W-1] || dxr[CALC_W-1] || dyb[CALC_W-1];
    border  = (dxl < ONE) || (dyt < ONE) || (dxr < ONE) || (dyb < ONE);
  end

  assign wr_en   = cmd_i.step && (!draw_q || (!outside && (border || filled_q)));
  assign wr_addr = base_q + ADDR_W'(col_q);
  assign wr_data = draw_q ? fill_q : bg_q;

  // Read side.
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_zero, rd_zero_q;
  logic [CHAR_W-1:0] rd_data_q, pixel_char_q;

  assign rd_addr = ADDR_W'(32'(pixel_row_i) * MAX_WIDTH + 32'(pixel_col_i));
  assign rd_zero = ({1'b0, pixel_col_i} >= aw) || ({1'b0, pixel_row_i} >= ah);

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_zero_q <= rd_zero;
    end
    if (cmd_i.out_load) begin
      pixel_char_q <= rd_zero_q ? '0 : rd_data_q;
    end
  end

  assign pixel_char_o = pixel_char_q;

endmodule

/* src/rectangle_raster_engine_top.sv */
// Top level of the rectangle raster engine: controller, datapath and channels.
// Clear and draw scan the active area one pixel per cycle, set by the single write port
// of the canvas store; an empty area is not scanned. A read captures the canvas entry
// in a read register at its acceptance, then moves it into the output register and
// raises out valid once the output register is free.
// Reset clears state machine, scan counters, out valid, config (256, 256, space); canvas undefined.
module rectangle_raster_engine_top import rre_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rre_in_if.sink                in_i,
  rre_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequence transactions: accept in idle, hold off input during scan and
  // while a read result waits for the output register.
  rre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.operation),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Hold config, classify pixels, write and read the canvas store.
  rre_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (in_i.operation),
    .filled_i      (in_i.filled),
    .rect_x_i      (in_i.rect_x),
    .rect_y_i      (in_i.rect_y),
    .rect_width_i  (in_i.rect_width),
    .rect_height_i (in_i.rect_height),
    .fill_char_i   (in_i.fill_char),
    .pixel_col_i   (in_i.pixel_col),
    .pixel_row_i   (in_i.pixel_row),
    .pixel_char_o  (out_o.pixel_char)
  );

endmodule

/* dv/rectangle_raster_engine_top_tb.sv */
// Self-checking testbench of the rectangle raster engine: clear, draw and read transactions.
module rectangle_raster_engine_top_tb;
  import rre_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam longint STOP_CYCLES = 3_000_000;
  localparam int RANDOM_ITEMS  = 70;
  localparam int CANVAS_DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int UNIT          = 1 << DEF_FRAC_BITS;

  // Operation code with no meaning: the block drops it without a result.
  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [CHAR_W-1:0] CH_R      = "R";

  // One input transaction as the channel carries it.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               filled;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic [CHAR_W-1:0]  ch;
    logic [PIX_W-1:0]   col;
    logic [PIX_W-1:0]   row;
  } raster_item_t;

  // Canvas mirror: replays accepted transactions and holds the pixel_char values
  // that pending reads must return, oldest first.
  class canvas_scoreboard;
    logic [CHAR_W-1:0] pix [CANVAS_DEPTH];
    logic [SCAN_W-1:0] width_r;
    logic [SCAN_W-1:0] height_r;
    logic [CHAR_W-1:0] bg_r;
    logic [CHAR_W-1:0] read_chars [$];
    int                errors;

    function new();
      width_r  = RST_CANVAS_WIDTH;
      height_r = RST_CANVAS_HEIGHT;
      bg_r     = RST_BACKGROUND;
      errors   = 0;
    endfunction

    function int active_w();
      return (width_r > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_r);
    endfunction

    function int active_h();
      return (height_r > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_r);
    endfunction

    function int pending();
      return read_chars.size();
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CANVAS_WIDTH:  width_r = data;
        CFG_CANVAS_HEIGHT: height_r = data;
        CFG_BACKGROUND:    bg_r = data[CHAR_W-1:0];
        default: ;
      endcase
    endfunction

    // Scan the active area once; a clear writes the background, a draw
    // classifies every pixel against the rectangle in exact 64-bit math.
    function void paint(raster_item_t it);
      longint x0, y0, x1, y1, wv, hv, px, py;
      bit     on_border;
      int     aw, ah;
      x0 = $signed(it.x);
      y0 = $signed(it.y);
      wv = it.w;
      hv = it.h;
      x1 = x0 + wv;
      y1 = y0 + hv;
      aw = active_w();
      ah = active_h();
      for (int r = 0; r < ah; r++) begin
        for (int c = 0; c < aw; c++) begin
          px = longint'(c) * UNIT;
          py = longint'(r) * UNIT;
          if (it.op == OP_CLEAR) begin
            pix[r * DEF_MAX_WIDTH + c] = bg_r;
          end else if (px >= x0 && px <= x1 && py >= y0 && py <= y1) begin
            on_border = (px - x0 < UNIT) || (py - y0 < UNIT) ||
                        (x1 - px < UNIT) || (y1 - py < UNIT);
            if (on_border || it.filled) pix[r * DEF_MAX_WIDTH + c] = it.ch;
          end
        end
      end
    endfunction

    function void note_item(raster_item_t it);
      case (it.op)
        OP_CLEAR, OP_DRAW: paint(it);
        OP_READ: begin
          if (it.col < active_w() && it.row < active_h())
            read_chars.push_back(pix[it.row * DEF_MAX_WIDTH + it.col]);
          else
            read_chars.push_back('0);
        end
        default: ;
      endcase
    endfunction

    function void check_char(logic [CHAR_W-1:0] got);
      logic [CHAR_W-1:0] want;
      if (read_chars.size() == 0) begin
        errors++;
        $display("%0t: pixel_char expected none actual %02h", $time, got);
      end else begin
        want = read_chars.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: pixel_char expected %02h actual %02h", $time, want, got);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rre_in_if  in_if ();
  rre_out_if out_if ();

  canvas_scoreboard sb;
  int sent = 0;
  int src_idle = 30;
  int dst_idle = 48;

  rectangle_raster_engine_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  // Stop a hung run; the bound is several times the slowest correct run.
  initial begin
    #(STOP_CYCLES * 2 * CLK_HALF);
    $display("tb: failure");
    $finish;
  end

  // Result side: check the transaction seen at this edge, then pick the
  // ready level for the next edge.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready) sb.check_char(out_if.pixel_char);
      out_if.ready <= ($urandom_range(99) >= dst_idle);
    end
  end

  function automatic raster_item_t noise_item();
    raster_item_t it;
    it.op     = OP_W'($urandom);
    it.filled = 1'($urandom);
    it.x      = COORD_W'($urandom);
    it.y      = COORD_W'($urandom);
    it.w      = SIZE_W'($urandom);
    it.h      = SIZE_W'($urandom);
    it.ch     = CHAR_W'($urandom);
    it.col    = PIX_W'($urandom);
    it.row    = PIX_W'($urandom);
    return it;
  endfunction

  function automatic raster_item_t op_item(logic [OP_W-1:0] op);
    raster_item_t it;
    it    = noise_item();
    it.op = op;
    return it;
  endfunction

  function automatic raster_item_t draw_item(bit filled, int x, int y, int w, int h,
                                             logic [CHAR_W-1:0] ch);
    raster_item_t it;
    it        = op_item(OP_DRAW);
    it.filled = filled;
    it.x      = COORD_W'(x);
    it.y      = COORD_W'(y);
    it.w      = SIZE_W'(w);
    it.h      = SIZE_W'(h);
    it.ch     = ch;
    return it;
  endfunction

  function automatic raster_item_t read_item(int col, int row);
    raster_item_t it;
    it     = op_item(OP_READ);
    it.col = PIX_W'(col);
    it.row = PIX_W'(row);
    return it;
  endfunction

  // Offer one transaction and hold it until the block takes it. Idle gaps
  // come before valid rises; valid stays high between back-to-back items.
  task automatic send(raster_item_t it);
    if (sent < 42) begin
      src_idle = 30;
      dst_idle = 48;
    end else if (sent < 84) begin
      src_idle = 48;
      dst_idle = 30;
    end else begin
      src_idle = 0;
      dst_idle = 0;
    end
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= it.op;
    in_if.filled      <= it.filled;
    in_if.rect_x      <= it.x;
    in_if.rect_y      <= it.y;
    in_if.rect_width  <= it.w;
    in_if.rect_height <= it.h;
    in_if.fill_char   <= it.ch;
    in_if.pixel_col   <= it.col;
    in_if.pixel_row   <= it.row;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_item(it);
    sent++;
  endtask

  // Drain the block: drop valid, wait for every pending read, then let a
  // scan of the current active area run out.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (sb.active_w() * sb.active_h() + 8) @(posedge clk_i);
  endtask

  // Write all three registers, one per edge; only call while idle.
  task automatic configure(int w, int h, int bg);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CANVAS_WIDTH;
    cfg_data_i <= CFG_DATA_W'(w);
    @(posedge clk_i);
    sb.set_reg(CFG_CANVAS_WIDTH, CFG_DATA_W'(w));
    cfg_idx_i  <= CFG_CANVAS_HEIGHT;
    cfg_data_i <= CFG_DATA_W'(h);
    @(posedge clk_i);
    sb.set_reg(CFG_CANVAS_HEIGHT, CFG_DATA_W'(h));
    cfg_idx_i  <= CFG_BACKGROUND;
    cfg_data_i <= CFG_DATA_W'(bg);
    @(posedge clk_i);
    sb.set_reg(CFG_BACKGROUND, CFG_DATA_W'(bg));
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    int rnd_items;
    int n, aw, ah, x, y, w, h, pick;
    sb = new();

    // Hold every input at a known value and keep reset low.
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_CANVAS_WIDTH;
    cfg_data_i        <= '0;
    in_if.valid       <= 1'b0;
    in_if.operation   <= OP_CLEAR;
    in_if.filled      <= 1'b0;
    in_if.rect_x      <= '0;
    in_if.rect_y      <= '0;
    in_if.rect_width  <= '0;
    in_if.rect_height <= '0;
    in_if.fill_char   <= '0;
    in_if.pixel_col   <= '0;
    in_if.pixel_row   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: full 256 x 256 canvas, space background. Keep
    // the scans here few since each one walks 65536 pixels.
    send(op_item(OP_UNUSED));
    send(op_item(OP_CLEAR));
    // Band wider than the canvas with fractional left and top edges.
    send(draw_item(1, -2 * UNIT - 64, 100 * UNIT + 128, 300 * UNIT, 3 * UNIT, 8'h2A));
    // Outline whose right and bottom edges lie far past the canvas.
    send(draw_item(0, 30 * UNIT, 40 * UNIT, 131071, 131071, CH_R));
    send(read_item(0, 0));
    send(read_item(0, 102));
    send(read_item(255, 101));
    send(read_item(200, 40));
    send(read_item(31, 41));

    // Small canvas, background at its top value.
    settle();
    configure(16, 12, 255);
    send(op_item(OP_CLEAR));
    // Extreme corners: both rectangles miss the canvas entirely.
    send(draw_item(1, -131072, 0, 131071, 12 * UNIT, 8'h11));
    send(draw_item(1, 131071, 131071, 0, 0, 8'h22));
    // Zero-size rectangle on a pixel: a single border pixel.
    send(draw_item(0, 3 * UNIT, 4 * UNIT, 0, 0, 8'h00));
    send(draw_item(1, 5 * UNIT + 128, 2 * UNIT + 192, 6 * UNIT, 5 * UNIT + 64, "A"));
    send(draw_item(0, 0, 0, 15 * UNIT, 11 * UNIT, "+"));
    send(read_item(3, 4));
    send(read_item(6, 3));
    send(read_item(8, 5));
    send(read_item(15, 11));
    send(read_item(2, 2));
    send(read_item(16, 0));
    send(read_item(255, 255));

    // Oversized width saturates to the maximum.
    settle();
    configure(511, 2, "#");
    send(op_item(OP_CLEAR));
    send(read_item(255, 1));
    send(read_item(0, 2));

    // Empty active area: scans write nothing, every read is outside.
    settle();
    configure(0, 0, 0);
    send(op_item(OP_CLEAR));
    send(draw_item(1, 0, 0, 4 * UNIT, 4 * UNIT, 8'h5A));
    send(read_item(0, 0));

    // Random phases: new settings, a clear so every active pixel is written,
    // then a mix of draws, reads, clears and the odd dropped code.
    rnd_items = 0;
    while (rnd_items < RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(9);
      case (pick)
        0:       configure(0, $urandom_range(1, 20), $urandom_range(255));
        1:       configure($urandom_range(1, 20), 0, $urandom_range(255));
        2:       configure($urandom_range(257, 511), $urandom_range(1, 3), $urandom_range(255));
        3:       configure($urandom_range(1, 3), $urandom_range(257, 511), $urandom_range(255));
        4:       configure(256, $urandom_range(1, 3), $urandom_range(255));
        default: configure($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(255));
      endcase
      aw = sb.active_w();
      ah = sb.active_h();
      send(op_item(OP_CLEAR));
      rnd_items++;
      n = $urandom_range(8, 16);
      repeat (n) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          send(op_item(OP_CLEAR));
          rnd_items++;
        end else if (pick < 46) begin
          pick = $urandom_range(9);
          if (pick == 0) begin
            // Full-range coordinates and sizes.
            send(op_item(OP_DRAW));
          end else begin
            x = int'($urandom_range(0, (aw + 6) * UNIT)) - 3 * UNIT;
            y = int'($urandom_range(0, (ah + 6) * UNIT)) - 3 * UNIT;
            if (pick == 1) begin
              // Narrower than two units: border only.
              w = $urandom_range(0, UNIT + 40);
              h = $urandom_range(0, UNIT + 40);
            end else begin
              w = $urandom_range(0, (aw + 4) * UNIT);
              h = $urandom_range(0, (ah + 4) * UNIT);
            end
            if ($urandom_range(1)) begin
              x = x & ~(UNIT - 1);
              y = y & ~(UNIT - 1);
              w = w & ~(UNIT - 1);
              h = h & ~(UNIT - 1);
            end
            send(draw_item($urandom_range(1), x, y, w, h, CHAR_W'($urandom)));
          end
          rnd_items++;
        end else if (pick < 94) begin
          if (aw > 0 && ah > 0 && $urandom_range(2) != 0)
            send(read_item($urandom_range(0, aw - 1), $urandom_range(0, ah - 1)));
          else
            send(read_item($urandom_range(255), $urandom_range(255)));
          rnd_items++;
        end else begin
          send(op_item(OP_UNUSED));
        end
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
